### rtl/cwdp_pkg.sv
// shared constants for the packed csi word to double pair converter
// no dependencies; used by the core and its checker
package cwdp_pkg;

    localparam int WORD_W     = 32;
    localparam int EXP_W      = 6;
    localparam int MANT_W     = 11;
    localparam int LZC_W      = 4;
    localparam int BEXP_W     = 11;
    localparam int FRAC_TOP_W = MANT_W - 1;
    localparam int DOUBLE_W   = 64;

    // field positions inside the packed word
    localparam int EXP_LSB    = 0;
    localparam int IMAG_LSB   = 6;
    localparam int IMAG_SIGN  = 17;
    localparam int REAL_LSB   = 18;
    localparam int REAL_SIGN  = 29;

    // double layout
    localparam int FRAC_POS   = 42;
    localparam int EXP_POS    = 52;
    localparam int SIGN_POS   = 63;

    localparam int EXP_OFFSET = 31;
    localparam int EXP_BIAS   = 1023;
    localparam int BEXP_MIN   = EXP_BIAS - EXP_OFFSET - (MANT_W - 2);
    localparam int BEXP_MAX   = EXP_BIAS - EXP_OFFSET + (1 << EXP_W) - 1;

    localparam logic [BEXP_W-1:0] BEXP_ADJ = BEXP_W'(EXP_BIAS - EXP_OFFSET);
    localparam logic [BEXP_W-1:0] BEXP_ONE = BEXP_W'(EXP_BIAS);

    typedef struct packed {
        logic              sign;
        logic [MANT_W-1:0] mant;
    } t_part;

endpackage

### rtl/csi_word_to_double_pair_core.sv
// Converts one packed csi word into two IEEE-754 double bit patterns.
// Usage:
//   input channel  : i_valid / o_ready with i_packed_word and i_last_in
//   output channel : o_valid / i_ready with o_real_bits, o_imag_bits, o_last_out
//   A transaction moves on each rising edge where valid and ready are both high.
// Pipeline: three register stages (unpack and bias the exponent, count leading
// zeros of both mantissas, normalize and assemble), the last one being the
// output register. A taken word passes through stage 1 and stage 2 before its
// result sits in the output register and o_valid rises.
// Throughput is one transaction per cycle; each stage has its own valid bit
// and advances when it is empty or the stage after it advances, so the rate
// is set only by how often the receiver takes results.
// When the receiver holds i_ready low, the stages fill up and o_ready falls
// once all three hold an item; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears the valid bits; data registers
// keep whatever they hold. Bits 31:30 of the packed word are ignored.
// A mantissa of zero or one gives +1.0 or -1.0 for that part.
// Depends on cwdp_pkg.
module csi_word_to_double_pair_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cwdp_pkg::WORD_W-1:0]   i_packed_word,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cwdp_pkg::DOUBLE_W-1:0] o_real_bits,
    output logic [cwdp_pkg::DOUBLE_W-1:0] o_imag_bits,
    output logic                          o_last_out
);

    // position of the leading one counted down from the top mantissa bit
    function automatic logic [cwdp_pkg::LZC_W-1:0] lead_zeros(
        input logic [cwdp_pkg::MANT_W-1:0] mant
    );
        logic [cwdp_pkg::LZC_W-1:0] lz;
        lz = '0;
        for (int k = 0; k < cwdp_pkg::MANT_W; k++) begin
            if (mant[k]) begin
                lz = cwdp_pkg::LZC_W'(cwdp_pkg::MANT_W - 1 - k);
            end
        end
        return lz;
    endfunction

    function automatic logic [cwdp_pkg::DOUBLE_W-1:0] build_double(
        input cwdp_pkg::t_part               part,
        input logic [cwdp_pkg::LZC_W-1:0]    lz,
        input logic                          unity,
        input logic [cwdp_pkg::BEXP_W-1:0]   bexp
    );
        logic [cwdp_pkg::MANT_W-1:0]     norm;
        logic [cwdp_pkg::BEXP_W-1:0]     exp_f;
        logic [cwdp_pkg::FRAC_TOP_W-1:0] frac;
        norm  = part.mant << lz;
        exp_f = unity ? cwdp_pkg::BEXP_ONE
                      : bexp - cwdp_pkg::BEXP_W'(lz);
        frac  = unity ? '0 : norm[cwdp_pkg::FRAC_TOP_W-1:0];
        return {part.sign, exp_f, frac, cwdp_pkg::FRAC_POS'(0)};
    endfunction

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // stage 1: unpacked fields
    cwdp_pkg::t_part                r_re1, r_im1;
    logic [cwdp_pkg::BEXP_W-1:0]    r_bexp1;
    logic                           r_last1;

    // stage 2: leading zero counts
    cwdp_pkg::t_part                r_re2, r_im2;
    logic [cwdp_pkg::BEXP_W-1:0]    r_bexp2;
    logic                           r_last2;
    logic [cwdp_pkg::LZC_W-1:0]     r_lz_re2, r_lz_im2;
    logic                           r_one_re2, r_one_im2;

    // stage 3: output register
    logic [cwdp_pkg::DOUBLE_W-1:0]  r_real3, r_imag3;
    logic                           r_last3;

    logic [cwdp_pkg::BEXP_W-1:0]    n_bexp1;
    logic [cwdp_pkg::EXP_W-1:0]     word_exp;

    assign word_exp = i_packed_word[cwdp_pkg::EXP_LSB +: cwdp_pkg::EXP_W];
    assign n_bexp1  = cwdp_pkg::BEXP_W'(word_exp) + cwdp_pkg::BEXP_ADJ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_re1.sign <= i_packed_word[cwdp_pkg::REAL_SIGN];
            r_re1.mant <= i_packed_word[cwdp_pkg::REAL_LSB +: cwdp_pkg::MANT_W];
            r_im1.sign <= i_packed_word[cwdp_pkg::IMAG_SIGN];
            r_im1.mant <= i_packed_word[cwdp_pkg::IMAG_LSB +: cwdp_pkg::MANT_W];
            r_bexp1    <= n_bexp1;
            r_last1    <= i_last_in;
        end
        if (adv2) begin
            r_re2     <= r_re1;
            r_im2     <= r_im1;
            r_bexp2   <= r_bexp1;
            r_last2   <= r_last1;
            r_lz_re2  <= lead_zeros(r_re1.mant);
            r_lz_im2  <= lead_zeros(r_im1.mant);
            // one would need a full ten-bit shift and zero has no leading one
            r_one_re2 <= (r_re1.mant[cwdp_pkg::MANT_W-1:1] == '0);
            r_one_im2 <= (r_im1.mant[cwdp_pkg::MANT_W-1:1] == '0);
        end
        if (adv3) begin
            r_real3 <= build_double(r_re2, r_lz_re2, r_one_re2, r_bexp2);
            r_imag3 <= build_double(r_im2, r_lz_im2, r_one_im2, r_bexp2);
            r_last3 <= r_last2;
        end
    end

    assign o_valid     = r_v3;
    assign o_real_bits = r_real3;
    assign o_imag_bits = r_imag3;
    assign o_last_out  = r_last3;

endmodule

### rtl/cwdp_checker.sv
// port-level checks for csi_word_to_double_pair_core, bound to the top level
// depends on cwdp_pkg
module cwdp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [cwdp_pkg::DOUBLE_W-1:0] o_real_bits,
    input logic [cwdp_pkg::DOUBLE_W-1:0] o_imag_bits,
    input logic                          o_last_out
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_real_bits)
            && $stable(o_imag_bits) && $stable(o_last_out))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // only the top ten fraction bits can be set
    a_low_frac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_real_bits[cwdp_pkg::FRAC_POS-1:0] == '0
            && o_imag_bits[cwdp_pkg::FRAC_POS-1:0] == '0)
        else $error("low fraction bits not zero");

    // biased exponent stays inside the reachable window
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_real_bits[cwdp_pkg::SIGN_POS-1:cwdp_pkg::EXP_POS] >= cwdp_pkg::BEXP_MIN
            && o_real_bits[cwdp_pkg::SIGN_POS-1:cwdp_pkg::EXP_POS] <= cwdp_pkg::BEXP_MAX
            && o_imag_bits[cwdp_pkg::SIGN_POS-1:cwdp_pkg::EXP_POS] >= cwdp_pkg::BEXP_MIN
            && o_imag_bits[cwdp_pkg::SIGN_POS-1:cwdp_pkg::EXP_POS] <= cwdp_pkg::BEXP_MAX)
        else $error("exponent out of range");

endmodule

bind csi_word_to_double_pair_core cwdp_checker u_cwdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_real_bits (o_real_bits),
    .o_imag_bits (o_imag_bits),
    .o_last_out  (o_last_out)
);

### tb/sv/csi_word_to_double_pair_checker.sv
// transaction checker for the csi word to double pair converter
// predicts both doubles from each accepted input word; depends on cwdp_pkg
module csi_word_to_double_pair_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready_in,
    input  logic [cwdp_pkg::WORD_W-1:0]   i_packed_word,
    input  logic                          i_last_in,
    input  logic                          i_valid_out,
    input  logic                          i_ready,
    input  logic [cwdp_pkg::DOUBLE_W-1:0] i_real_bits,
    input  logic [cwdp_pkg::DOUBLE_W-1:0] i_imag_bits,
    input  logic                          i_last_out,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [cwdp_pkg::DOUBLE_W-1:0] real_bits;
        logic [cwdp_pkg::DOUBLE_W-1:0] imag_bits;
        logic                          last;
    } t_double_pair;

    t_double_pair expected_pairs[$];

    function automatic logic [cwdp_pkg::DOUBLE_W-1:0] part_bits(
        input logic                        sign,
        input logic [cwdp_pkg::MANT_W-1:0] mant,
        input logic [cwdp_pkg::BEXP_W-1:0] bexp
    );
        logic [cwdp_pkg::MANT_W-1:0] norm;
        logic [cwdp_pkg::BEXP_W-1:0] expo;
        norm = mant;
        expo = bexp;
        if (mant <= 1) begin
            // nothing to normalize: the part reads as plus or minus one
            expo = cwdp_pkg::BEXP_W'(cwdp_pkg::EXP_BIAS);
            norm = '0;
        end else begin
            while (!norm[cwdp_pkg::MANT_W-1]) begin
                norm = norm << 1;
                expo = expo - 1'b1;
            end
        end
        return {sign, expo, norm[cwdp_pkg::FRAC_TOP_W-1:0],
                {cwdp_pkg::FRAC_POS{1'b0}}};
    endfunction

    function automatic t_double_pair convert_word(
        input logic [cwdp_pkg::WORD_W-1:0] word,
        input logic                        last
    );
        t_double_pair                pair;
        logic [cwdp_pkg::BEXP_W-1:0] bexp;
        bexp = cwdp_pkg::BEXP_W'(word[cwdp_pkg::EXP_LSB +: cwdp_pkg::EXP_W])
             + cwdp_pkg::BEXP_W'(cwdp_pkg::EXP_BIAS - cwdp_pkg::EXP_OFFSET);
        pair.real_bits = part_bits(word[cwdp_pkg::REAL_SIGN],
                                   word[cwdp_pkg::REAL_LSB +: cwdp_pkg::MANT_W], bexp);
        pair.imag_bits = part_bits(word[cwdp_pkg::IMAG_SIGN],
                                   word[cwdp_pkg::IMAG_LSB +: cwdp_pkg::MANT_W], bexp);
        pair.last      = last;
        return pair;
    endfunction

    function automatic int field_mismatch(
        input string         name,
        input logic [63:0]   want,
        input logic [63:0]   got
    );
        if (want !== got) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_double_pair want;
        int           errs;
        int           delta;
        errs  = 0;
        delta = 0;
        if (i_rst_n) begin
            if (i_valid_out && i_ready) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t unexpected result real %h imag %h last %b",
                             $time, i_real_bits, i_imag_bits, i_last_out);
                    errs++;
                end else begin
                    want = expected_pairs.pop_front();
                    errs += field_mismatch("real_bits", want.real_bits, i_real_bits);
                    errs += field_mismatch("imag_bits", want.imag_bits, i_imag_bits);
                    errs += field_mismatch("last_out", 64'(want.last), 64'(i_last_out));
                    delta--;
                end
            end
            if (i_valid && i_ready_in) begin
                expected_pairs.push_back(convert_word(i_packed_word, i_last_in));
                delta++;
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= o_pending + delta;
    end

endmodule

### tb/sv/tb_csi_word_to_double_pair_core.sv
// testbench top for csi_word_to_double_pair_core: directed and random words
// with random stalls on both sides; depends on cwdp_pkg and the checker module
module tb_csi_word_to_double_pair_core;

    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_WORDS = 1800;
    localparam int QUIET_FIRST  = 900;
    localparam int QUIET_LAST   = 1200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic [cwdp_pkg::WORD_W-1:0]   i_packed_word = '0;
    logic                          i_last_in     = 1'b0;
    logic                          i_ready       = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [cwdp_pkg::DOUBLE_W-1:0] o_real_bits;
    logic [cwdp_pkg::DOUBLE_W-1:0] o_imag_bits;
    logic                          o_last_out;
    logic                          quiet         = 1'b0;
    int                            fail_count;
    int                            pending;
    int                            stall_cycles  = 0;

    csi_word_to_double_pair_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_packed_word (i_packed_word),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_real_bits   (o_real_bits),
        .o_imag_bits   (o_imag_bits),
        .o_last_out    (o_last_out)
    );

    csi_word_to_double_pair_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_packed_word (i_packed_word),
        .i_last_in     (i_last_in),
        .i_valid_out   (o_valid),
        .i_ready       (i_ready),
        .i_real_bits   (o_real_bits),
        .i_imag_bits   (o_imag_bits),
        .i_last_out    (o_last_out),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL csi_word_to_double_pair_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [cwdp_pkg::WORD_W-1:0] pack_word(
        input logic [1:0]                  spare,
        input logic                        re_sign,
        input logic [cwdp_pkg::MANT_W-1:0] re_mant,
        input logic                        im_sign,
        input logic [cwdp_pkg::MANT_W-1:0] im_mant,
        input logic [cwdp_pkg::EXP_W-1:0]  expo
    );
        return {spare, re_sign, re_mant, im_sign, im_mant, expo};
    endfunction

    // spreads mantissas over every leading zero count, tiny values included
    function automatic logic [cwdp_pkg::MANT_W-1:0] random_mant();
        int                          width;
        logic [cwdp_pkg::MANT_W-1:0] mant;
        if ($urandom_range(0, 9) == 0) begin
            return cwdp_pkg::MANT_W'($urandom_range(0, 3));
        end
        width = $urandom_range(1, cwdp_pkg::MANT_W);
        mant  = cwdp_pkg::MANT_W'($urandom) & cwdp_pkg::MANT_W'((1 << width) - 1);
        mant[width-1] = 1'b1;
        return mant;
    endfunction

    function automatic logic [cwdp_pkg::EXP_W-1:0] random_exp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return cwdp_pkg::EXP_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [cwdp_pkg::WORD_W-1:0] word, input logic last);
        if (!quiet && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_packed_word <= word;
        i_last_in     <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [cwdp_pkg::MANT_W-1:0] mant_a;
        logic [cwdp_pkg::MANT_W-1:0] mant_b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, the plus or minus one parts and ignored top bits
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        send_word(pack_word(2'b00, 1'b1, 11'd0, 1'b0, 11'd1, 6'd0), 1'b0);
        send_word(pack_word(2'b11, 1'b0, 11'd1, 1'b1, 11'd0, 6'd63), 1'b1);
        send_word(pack_word(2'b01, 1'b1, 11'd2, 1'b1, 11'd3, 6'd0), 1'b0);
        send_word(pack_word(2'b10, 1'b0, 11'h400, 1'b1, 11'h7ff, 6'd63), 1'b0);
        send_word(pack_word(2'b11, 1'b1, 11'h7ff, 1'b0, 11'h400, 6'd31), 1'b1);
        send_word(pack_word(2'b10, 1'b0, 11'h555, 1'b1, 11'h2aa, 6'h2a), 1'b0);
        // every normalize shift count from none to nine
        for (int shift = 0; shift < cwdp_pkg::MANT_W - 1; shift++) begin
            mant_a = 11'h7ff >> shift;
            mant_b = 11'h400 >> (cwdp_pkg::MANT_W - 2 - shift);
            send_word(pack_word(2'(shift), shift[0], mant_a, ~shift[0], mant_b,
                                shift[0] ? 6'd63 : 6'd0),
                      shift == cwdp_pkg::MANT_W - 2);
        end

        // hold the sender until everything directed has come out
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet <= (n >= QUIET_FIRST && n < QUIET_LAST);
            if (n == RANDOM_WORDS / 2) begin
                drain_results();
            end
            send_word(pack_word(2'($urandom), 1'($urandom), random_mant(),
                                1'($urandom), random_mant(), random_exp()),
                      $urandom_range(0, 7) == 0);
        end

        quiet <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS csi_word_to_double_pair_core");
        end else begin
            $display("FAIL csi_word_to_double_pair_core");
        end
        $finish;
    end

endmodule
